// ===== hw/rtl/dfr_pkg.sv =====
// shared widths, opcodes and status codes of the deduplicating queue
package dfr_pkg;

    localparam int VALUE_W  = 4;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;

    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    // opcodes
    localparam opcode_t OP_ADD    = 3'd0;
    localparam opcode_t OP_POP    = 3'd1;
    localparam opcode_t OP_PEEK   = 3'd2;
    localparam opcode_t OP_REMOVE = 3'd3;
    localparam opcode_t OP_CLEAR  = 3'd4;

    // result status codes
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_MISSING = 2'd1;
    localparam status_t ST_DUP     = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

endpackage

// ===== hw/rtl/dfr_req_if.sv =====
// request channel: opcode and value with valid/ready handshake
interface dfr_req_if;

    logic              valid;
    logic              ready;
    dfr_pkg::opcode_t  opcode;
    dfr_pkg::value_t   value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);

endinterface

// ===== hw/rtl/dfr_rsp_if.sv =====
// response channel: result value, status and empty flag with valid/ready handshake
interface dfr_rsp_if;

    logic              valid;
    logic              ready;
    dfr_pkg::value_t   result_value;
    dfr_pkg::status_t  status;
    logic              now_empty;

    modport source (output valid, output result_value, output status, output now_empty,
                    input ready);
    modport sink   (input valid, input result_value, input status, input now_empty,
                    output ready);

endinterface

// ===== hw/rtl/dedup_fifo_with_remove_unit.sv =====
// Deduplicating request queue with remove-by-value. Each request transaction
// (add, pop, peek, remove, clear) gives exactly one response transaction. Entries
// live in a single-port-read, single-port-write memory of DEPTH words with a
// registered read; one request is worked on at a time. Clear and unknown
// opcodes load the response register at the accept edge, so the response is
// valid in the next cycle. Add, pop, peek and remove scan the queue from the
// oldest entry, one memory read per cycle, and answer when an entry matches or
// the scan runs past the newest entry. Pop and remove then close the gap with a
// read-ahead copy loop that moves one entry per cycle. The slowest requests are
// a pop or a successful remove on a full queue. A new request is taken only
// when the unit is idle and its response register is free or being emptied,
// so the next request can be accepted in the same cycle as the previous
// response is taken.
module dedup_fifo_with_remove_unit #(
    parameter int DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    dfr_req_if.sink    req,
    dfr_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ADR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    // entry storage
    dfr_pkg::value_t mem [DEPTH];

    logic [1:0]         state_reg,   state_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [CNT_W-1:0]   addr_reg,    addr_next;
    logic               rd_vld_reg,  rd_vld_next;
    logic [CNT_W-1:0]   rd_idx_reg,  rd_idx_next;
    dfr_pkg::value_t    rd_data_reg;
    dfr_pkg::opcode_t   op_reg,      op_next;
    dfr_pkg::value_t    val_reg,     val_next;
    dfr_pkg::value_t    res_reg,     res_next;
    logic               out_vld_reg, out_vld_next;
    dfr_pkg::value_t    out_val_reg, out_val_next;
    dfr_pkg::status_t   out_st_reg,  out_st_next;
    logic               out_emp_reg, out_emp_next;

    logic               mem_re;
    logic [ADR_W-1:0]   mem_raddr;
    logic               mem_we;
    logic [ADR_W-1:0]   mem_waddr;
    dfr_pkg::value_t    mem_wdata;
    logic               accept;
    logic               out_free;
    logic               hit;
    logic [CNT_W-1:0]   wr_pos;

    // handshake
    assign out_free  = !out_vld_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign rsp.valid        = out_vld_reg;
    assign rsp.result_value = out_val_reg;
    assign rsp.status       = out_st_reg;
    assign rsp.now_empty    = out_emp_reg;

    // compare of the entry read in the previous cycle
    assign hit = rd_vld_reg &&
                 ((rd_data_reg == val_reg) || (op_reg == dfr_pkg::OP_POP) ||
                  (op_reg == dfr_pkg::OP_PEEK));
    assign wr_pos = rd_idx_reg - ONE_C;

    // control and next-state logic
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        addr_next    = addr_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        res_next     = res_reg;
        out_vld_next = out_vld_reg && !rsp.ready;
        out_val_next = out_val_reg;
        out_st_next  = out_st_reg;
        out_emp_next = out_emp_reg;
        mem_re       = 1'b0;
        mem_raddr    = addr_reg[ADR_W-1:0];
        mem_we       = 1'b0;
        mem_waddr    = count_reg[ADR_W-1:0];
        mem_wdata    = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req.opcode;
                    val_next = req.value;
                    addr_next = '0;
                    if ((req.opcode == dfr_pkg::OP_ADD) || (req.opcode == dfr_pkg::OP_POP) ||
                        (req.opcode == dfr_pkg::OP_PEEK) ||
                        (req.opcode == dfr_pkg::OP_REMOVE))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        // clear or no-op answers at once
                        if (req.opcode == dfr_pkg::OP_CLEAR)
                        begin
                            count_next = '0;
                        end
                        out_vld_next = 1'b1;
                        out_val_next = '0;
                        out_st_next  = dfr_pkg::ST_OK;
                        out_emp_next = (req.opcode == dfr_pkg::OP_CLEAR) || (count_reg == '0);
                    end
                end
            end

            S_SCAN:
            begin
                priority if (hit)
                begin
                    res_next = rd_data_reg;
                    unique case (op_reg)
                        dfr_pkg::OP_ADD:
                        begin
                            out_vld_next = 1'b1;
                            out_val_next = '0;
                            out_st_next  = dfr_pkg::ST_DUP;
                            out_emp_next = (count_reg == '0);
                            state_next   = S_IDLE;
                        end
                        dfr_pkg::OP_PEEK:
                        begin
                            out_vld_next = 1'b1;
                            out_val_next = rd_data_reg;
                            out_st_next  = dfr_pkg::ST_OK;
                            out_emp_next = (count_reg == '0);
                            state_next   = S_IDLE;
                        end
                        default:
                        begin
                            // pop or remove: copy the entries behind the hit forward
                            addr_next  = rd_idx_reg + ONE_C;
                            state_next = S_SHIFT;
                        end
                    endcase
                end
                else if (addr_reg < count_reg)
                begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = addr_reg;
                    addr_next   = addr_reg + ONE_C;
                end
                else if (!rd_vld_reg)
                begin
                    // scan ended without a match
                    out_vld_next = 1'b1;
                    out_val_next = '0;
                    state_next   = S_IDLE;
                    if (op_reg == dfr_pkg::OP_ADD)
                    begin
                        if (count_reg >= DEPTH_C)
                        begin
                            out_st_next  = dfr_pkg::ST_FULL;
                            out_emp_next = (count_reg == '0);
                        end
                        else
                        begin
                            mem_we       = 1'b1;
                            count_next   = count_reg + ONE_C;
                            out_val_next = val_reg;
                            out_st_next  = dfr_pkg::ST_OK;
                            out_emp_next = 1'b0;
                        end
                    end
                    else
                    begin
                        out_st_next  = dfr_pkg::ST_MISSING;
                        out_emp_next = (count_reg == '0);
                    end
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end
            end

            S_SHIFT:
            begin
                // write back the entry fetched last cycle one slot nearer the head
                if (rd_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_pos[ADR_W-1:0];
                    mem_wdata = rd_data_reg;
                end
                priority if (addr_reg < count_reg)
                begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = addr_reg;
                    addr_next   = addr_reg + ONE_C;
                end
                else if (!rd_vld_reg)
                begin
                    count_next   = count_reg - ONE_C;
                    out_vld_next = 1'b1;
                    out_val_next = res_reg;
                    out_st_next  = dfr_pkg::ST_OK;
                    out_emp_next = (count_reg == ONE_C);
                    state_next   = S_IDLE;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            addr_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            addr_reg    <= addr_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        op_reg      <= op_next;
        val_reg     <= val_next;
        res_reg     <= res_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
        out_emp_reg <= out_emp_next;
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

`ifndef SYNTH
    // fill level never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queue count above capacity");

    // gap closing only happens on a non-empty queue
    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (count_reg != '0))
        else $error("shift with empty queue");

    // failed operations carry a zero value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_st_reg != dfr_pkg::ST_OK)) |-> (out_val_reg == '0))
        else $error("nonzero value on failed response");

    // no request is taken while one is being worked on
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("request accepted while busy");

    // now_empty agrees with the fill level when a response appears
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> (out_emp_reg == (count_reg == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule
